[rtl/core/stfd_pkg.sv]
// Shared types, constants, and the sine table generator for the stereo tremolo delay core.
package stfd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int LFO_W        = 18;
    localparam int GAIN_W       = 19;
    localparam int TAP_W        = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIX    = 2'd3;

    localparam logic [15:0] VOLUME_RESET = 16'd16384;

    // 0.45 in Q1.15, applied to the sum before it goes back into the delay store.
    localparam logic signed [15:0] STORE_GAIN_Q15 = 16'sd14746;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       last_in;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_out;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINE,
        ST_LFO,
        ST_GAIN,
        ST_DRY,
        ST_SUM,
        ST_STORE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic k_load;
        logic sine_load;
        logic advance;
        logic lfo_load;
        logic gain_load;
    } lfo_ctrl_t;

    typedef struct packed {
        logic tap_load;
        logic wet_load;
        logic dry_load;
        logic sum_load;
        logic store_load;
        logic commit;
    } lane_ctrl_t;

    // Sine of a first-quadrant angle x (Q30 radians) by an 11th-order Taylor series,
    // returned in Q1.15 and negated for the lower half turn. Evaluated at elaboration.
    function automatic logic signed [15:0] sine_q15(longint unsigned x, logic negate);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        logic signed [15:0] mag;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 110;
        t = Q30_ONE - ((x2 * t) >> 30) / 72;
        t = Q30_ONE - ((x2 * t) >> 30) / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        s = (((x * t) >> 30) + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        mag = 16'(s);
        return negate ? -mag : mag;
    endfunction

endpackage

[rtl/core/stfd_lfo.sv]
// LFO phase accumulator, sine table and tremolo gain datapath shared by both lanes.
module stfd_lfo #(
    parameter int SINE_TABLE_SIZE = 1024,
    localparam int KW  = $clog2(SINE_TABLE_SIZE),
    localparam int SZW = $clog2(SINE_TABLE_SIZE + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stfd_pkg::lfo_ctrl_t                 ctrl,
    input  logic [31:0]                         step,
    input  logic [15:0]                         depth,
    input  logic [15:0]                         volume,
    output logic signed [stfd_pkg::GAIN_W-1:0]  gain
);

    localparam int PW = 32 + SZW;

    logic [31:0]                          phase_reg;
    logic [KW-1:0]                        k_reg;
    logic signed [15:0]                   sine_reg;
    logic signed [stfd_pkg::LFO_W-1:0]    lfo_reg;
    logic signed [stfd_pkg::GAIN_W-1:0]   gain_reg;

    logic [PW-1:0]                        k_prod;
    logic signed [32:0]                   depth_prod;
    logic signed [32:0]                   depth_rnd;
    logic signed [stfd_pkg::LFO_W-1:0]    lfo_next;
    logic signed [34:0]                   vol_prod;
    logic signed [34:0]                   vol_rnd;
    logic signed [stfd_pkg::GAIN_W-1:0]   gain_next;

    // Full-turn sine table, built from the series at elaboration.
    logic signed [15:0] sine_rom [SINE_TABLE_SIZE];

    for (genvar g = 0; g < SINE_TABLE_SIZE; g++)
    begin : g_rom
        localparam longint unsigned N4   = 4 * g;
        localparam longint unsigned QUAD = N4 / SINE_TABLE_SIZE;
        localparam longint unsigned REM  = N4 % SINE_TABLE_SIZE;
        localparam longint unsigned NUM  = (QUAD % 2 == 1) ? SINE_TABLE_SIZE - REM : REM;
        localparam longint unsigned XQ30 = stfd_pkg::HALF_PI_Q30 * NUM / SINE_TABLE_SIZE;
        assign sine_rom[g] = stfd_pkg::sine_q15(XQ30, QUAD >= 2);
    end

    assign k_prod     = phase_reg * SZW'(SINE_TABLE_SIZE);
    assign depth_prod = $signed({1'b0, depth}) * sine_reg;
    assign depth_rnd  = (depth_prod + 33'sd16384) >>> 15;
    assign lfo_next   = 18'sd32768 + depth_rnd[stfd_pkg::LFO_W-1:0];
    assign vol_prod   = $signed({1'b0, volume}) * lfo_reg;
    assign vol_rnd    = (vol_prod + 35'sd16384) >>> 15;
    assign gain_next  = vol_rnd[stfd_pkg::GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg <= phase_reg + step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.k_load)
        begin
            k_reg <= k_prod[32 +: KW];
        end
        if (ctrl.sine_load)
        begin
            sine_reg <= sine_rom[k_reg];
        end
        if (ctrl.lfo_load)
        begin
            lfo_reg <= lfo_next;
        end
        if (ctrl.gain_load)
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain = gain_reg;

endmodule

[rtl/core/stfd_lane.sv]
// One channel lane: delay store, dry and wet products, feedback write and output clip.
module stfd_lane #(
    parameter int DELAY_DEPTH = 32768,
    localparam int AW = $clog2(DELAY_DEPTH)
) (
    input  logic                                  clk,
    input  stfd_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [stfd_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [stfd_pkg::GAIN_W-1:0]    gain,
    input  logic [15:0]                           mix,
    input  logic [AW-1:0]                         rd_addr,
    input  logic [AW-1:0]                         wr_addr,
    input  logic                                  tap_ok,
    output logic signed [stfd_pkg::SAMPLE_W-1:0]  out_sample
);

    logic signed [stfd_pkg::TAP_W-1:0] store_mem [DELAY_DEPTH];

    logic signed [stfd_pkg::TAP_W-1:0]    tap_reg;
    logic signed [39:0]                   wet_reg;
    logic signed [34:0]                   dry_reg;
    logic signed [40:0]                   sum_reg;
    logic signed [55:0]                   store_prod_reg;
    logic signed [stfd_pkg::SAMPLE_W-1:0] out_reg;

    logic signed [40:0]                   wet_prod;
    logic signed [34:0]                   dry_prod;
    logic signed [40:0]                   sum_next;
    logic signed [55:0]                   store_prod;
    logic signed [40:0]                   out_sh;
    logic signed [stfd_pkg::SAMPLE_W-1:0] out_next;
    logic signed [55:0]                   store_sh;
    logic signed [stfd_pkg::TAP_W-1:0]    store_val;

    assign wet_prod   = tap_reg * $signed({1'b0, mix});
    assign dry_prod   = sample * gain;
    assign sum_next   = $signed({{5{dry_reg[34]}}, dry_reg, 1'b0}) + $signed({wet_reg[39], wet_reg});
    assign store_prod = sum_reg * stfd_pkg::STORE_GAIN_Q15;
    assign out_sh     = (sum_reg + 41'sd16384) >>> 15;
    assign store_sh   = (store_prod_reg + 56'sd536870912) >>> 30;

    always_comb
    begin
        if (out_sh > 41'sd32767)
        begin
            out_next = 16'sd32767;
        end
        else if (out_sh < -41'sd32767)
        begin
            out_next = -16'sd32767;
        end
        else
        begin
            out_next = out_sh[stfd_pkg::SAMPLE_W-1:0];
        end

        if (store_sh > 56'sd8388607)
        begin
            store_val = 24'sh7FFFFF;
        end
        else if (store_sh < -56'sd8388608)
        begin
            store_val = 24'sh800000;
        end
        else
        begin
            store_val = store_sh[stfd_pkg::TAP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            store_mem[wr_addr] <= store_val;
        end
        if (ctrl.tap_load)
        begin
            tap_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wet_load)
        begin
            wet_reg <= tap_ok ? wet_prod[39:0] : '0;
        end
        if (ctrl.dry_load)
        begin
            dry_reg <= dry_prod;
        end
        if (ctrl.sum_load)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.store_load)
        begin
            store_prod_reg <= store_prod;
            out_reg        <= out_next;
        end
    end

    assign out_sample = out_reg;

endmodule

[rtl/core/stereo_tremolo_feedback_delay_core.sv]
// Top level of the stereo tremolo with feedback delay: control, addressing and result merge.
//
//   Channel   Direction  Handshake                  Word
//   frame     in         frame_valid / frame_stall  stfd_pkg::frame_t (left, right, last)
//   result    out        result_valid/result_stall  stfd_pkg::result_t (left, right, last)
//   cfg       in         cfg_write                  cfg_index selects, cfg_data carries value
//
// A frame word is accepted at an edge where the sequencer is idle; it then steps through the
// SINE, LFO, GAIN, DRY, SUM, STORE and DONE states, and the edge that commits it loads the
// result register and returns the sequencer to idle. The states follow the registered multiplies
// of the LFO gain path and the lane datapath after it. One word is in flight at a time.
// A finished result waits in the output register; the next frame can be taken meanwhile,
// and only its final commit waits for the result register to be free.
// Reset clears the sequencer, the LFO phase and the write pointer, and sets the configuration to its defaults.
// The delay store is never swept: a fill flag and the write pointer mark entries not yet
// written since reset, and those read back as zero, so the block is usable right after reset.
module stereo_tremolo_feedback_delay_core #(
    parameter int FRAME_RATE_HZ   = 48000,
    parameter int DELAY_DEPTH     = 32768,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                frame_valid,
    output logic                                frame_stall,
    input  stfd_pkg::frame_t                    frame,

    output logic                                result_valid,
    input  logic                                result_stall,
    output stfd_pkg::result_t                   result,

    input  logic                                cfg_write,
    input  logic [stfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [stfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int SRW = $clog2(FRAME_RATE_HZ + 1);
    localparam int CW  = (SRW > AW) ? SRW : AW;

    // Configuration registers.
    logic [15:0] volume_reg;
    logic [31:0] step_reg;
    logic [15:0] depth_reg;
    logic [15:0] mix_reg;

    // Sequencer and delay addressing state.
    stfd_pkg::state_t state_reg;
    stfd_pkg::state_t state_next;
    logic [AW-1:0]    wi_reg;
    logic             full_reg;
    logic             result_valid_reg;

    // Per-frame payload registers.
    stfd_pkg::frame_t  frame_reg;
    stfd_pkg::result_t result_reg;
    logic [AW-1:0]     delay_reg;
    logic [AW-1:0]     rd_reg;
    logic              tap_ok_reg;

    stfd_pkg::lfo_ctrl_t  lfo_ctrl;
    stfd_pkg::lane_ctrl_t lane_ctrl;
    logic                 frame_take;
    logic                 addr_load;

    logic signed [stfd_pkg::GAIN_W-1:0]   gain;
    logic signed [stfd_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [stfd_pkg::SAMPLE_W-1:0] right_sample;

    logic [16+SRW-1:0] delay_prod;
    logic [CW-1:0]     delay_wide;
    logic [AW-1:0]     delay_clamped;
    logic [AW:0]       rd_diff;
    logic [AW:0]       rd_wrap;
    logic [AW-1:0]     rd_next;
    logic              tap_ok_next;

    // Configuration writes; the two-bit index covers all four registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= stfd_pkg::VOLUME_RESET;
            step_reg   <= '0;
            depth_reg  <= '0;
            mix_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                stfd_pkg::REG_VOLUME: volume_reg <= cfg_data[15:0];
                stfd_pkg::REG_STEP:   step_reg   <= cfg_data[31:0];
                stfd_pkg::REG_DEPTH:  depth_reg  <= cfg_data[15:0];
                stfd_pkg::REG_MIX:    mix_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // Echo length in frames follows the wet mix scaled by the frame rate, at least one and held inside the store.
    assign delay_prod = mix_reg * SRW'(FRAME_RATE_HZ);
    assign delay_wide = CW'(delay_prod[16 +: SRW]);

    always_comb
    begin
        if (delay_wide == '0)
        begin
            delay_clamped = AW'(1);
        end
        else if (delay_wide > CW'(DELAY_DEPTH - 1))
        begin
            delay_clamped = AW'(DELAY_DEPTH - 1);
        end
        else
        begin
            delay_clamped = delay_wide[AW-1:0];
        end
    end

    // Tap address, wrapped around the circular store. An entry behind the write
    // pointer is valid once written; after the first full lap every entry is.
    assign rd_diff     = {1'b0, wi_reg} - {1'b0, delay_reg};
    assign rd_wrap     = rd_diff + (AW+1)'(DELAY_DEPTH);
    assign rd_next     = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
    assign tap_ok_next = full_reg || (rd_next < wi_reg);

    // Sequencer: steps each frame through the shared LFO path and both lanes.
    always_comb
    begin
        state_next = state_reg;
        lfo_ctrl   = '0;
        lane_ctrl  = '0;
        frame_take = 1'b0;
        addr_load  = 1'b0;
        unique case (state_reg)
            stfd_pkg::ST_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_take      = 1'b1;
                    lfo_ctrl.k_load = 1'b1;
                    state_next      = stfd_pkg::ST_SINE;
                end
            end
            stfd_pkg::ST_SINE:
            begin
                lfo_ctrl.sine_load = 1'b1;
                lfo_ctrl.advance   = 1'b1;
                addr_load          = 1'b1;
                state_next         = stfd_pkg::ST_LFO;
            end
            stfd_pkg::ST_LFO:
            begin
                lfo_ctrl.lfo_load  = 1'b1;
                lane_ctrl.tap_load = 1'b1;
                state_next         = stfd_pkg::ST_GAIN;
            end
            stfd_pkg::ST_GAIN:
            begin
                lfo_ctrl.gain_load = 1'b1;
                lane_ctrl.wet_load = 1'b1;
                state_next         = stfd_pkg::ST_DRY;
            end
            stfd_pkg::ST_DRY:
            begin
                lane_ctrl.dry_load = 1'b1;
                state_next         = stfd_pkg::ST_SUM;
            end
            stfd_pkg::ST_SUM:
            begin
                lane_ctrl.sum_load = 1'b1;
                state_next         = stfd_pkg::ST_STORE;
            end
            stfd_pkg::ST_STORE:
            begin
                lane_ctrl.store_load = 1'b1;
                state_next           = stfd_pkg::ST_DONE;
            end
            stfd_pkg::ST_DONE:
            begin
                // The store write and the result load happen together, once the
                // output register is free.
                if (!result_valid_reg || !result_stall)
                begin
                    lane_ctrl.commit = 1'b1;
                    state_next       = stfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stfd_pkg::ST_IDLE;
            wi_reg           <= '0;
            full_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (lane_ctrl.commit)
            begin
                result_valid_reg <= 1'b1;
                if (wi_reg == AW'(DELAY_DEPTH - 1))
                begin
                    wi_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wi_reg <= wi_reg + 1'b1;
                end
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            frame_reg <= frame;
            delay_reg <= delay_clamped;
        end
        if (addr_load)
        begin
            rd_reg     <= rd_next;
            tap_ok_reg <= tap_ok_next;
        end
        if (lane_ctrl.commit)
        begin
            result_reg.left_out  <= left_sample;
            result_reg.right_out <= right_sample;
            result_reg.last_out  <= frame_reg.last_in;
        end
    end

    stfd_lfo #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_lfo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lfo_ctrl),
        .step   (step_reg),
        .depth  (depth_reg),
        .volume (volume_reg),
        .gain   (gain)
    );

    stfd_lane #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_lane_left (
        .clk        (clk),
        .ctrl       (lane_ctrl),
        .sample     (frame_reg.left_in),
        .gain       (gain),
        .mix        (mix_reg),
        .rd_addr    (rd_reg),
        .wr_addr    (wi_reg),
        .tap_ok     (tap_ok_reg),
        .out_sample (left_sample)
    );

    stfd_lane #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_lane_right (
        .clk        (clk),
        .ctrl       (lane_ctrl),
        .sample     (frame_reg.right_in),
        .gain       (gain),
        .mix        (mix_reg),
        .rd_addr    (rd_reg),
        .wr_addr    (wi_reg),
        .tap_ok     (tap_ok_reg),
        .out_sample (right_sample)
    );

    assign frame_stall  = (state_reg != stfd_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
